// File: rtl/core/erm_pkg.sv
`timescale 1ns / 1ps

package erm_pkg;

  // fixed field widths
  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned TS_W    = 64;

  // x1000 scaling grows the product by this many bits
  localparam int unsigned SCALE_BITS = 10;

  localparam logic [FREQ_W-1:0]  TIMER_FREQ_RST = 32'd10000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [OUT_W-1:0]   OUT_MAX        = '1;

  // blend denominator: new = (4*rate + 6*avg) / 10
  localparam logic [3:0] BLEND_DIV = 4'd10;

  // item kinds
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] rate_milli_hz;
    logic             updated;
  } out_word_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// File: rtl/core/event_rate_meter_ema.sv
`timescale 1ns / 1ps

// Channel | dir | handshake                 | word
// --------+-----+---------------------------+---------------------------------
// in      | in  | in_valid_i / in_stall_o   | erm_pkg::in_word_t (kind, ts)
// out     | out | out_valid_o / out_stall_i | erm_pkg::out_word_t (rate, upd)
// cfg     | in  | cfg_valid_i / cfg_ready_o | timer_freq, 32 bits
//
// A word that does not close a window goes through S_EVAL and S_FIN into the output register.
// Closing a window: 32x32 multiply, x1000 by shift-subtract, then 74 steps
// of the bit-serial divider; blending into a nonzero average adds a sum, then a divide
// by ten by shift-add and a remainder fix.
// Reset clears count, window, average and restores timer_freq to 10 MHz.
// in_stall_o is high while a word is in work; a result held by out_stall_i keeps the
// block in its last state, and the next word is taken once the result is loaded.
module event_rate_meter_ema #(
  parameter int unsigned TIME_WIDTH = 64,
  parameter int unsigned RATE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  erm_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output erm_pkg::out_word_t           out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [erm_pkg::FREQ_W-1:0]   cfg_data_i
);

  localparam int unsigned PROD_W = erm_pkg::COUNT_W + erm_pkg::FREQ_W;
  localparam int unsigned DVD_W  = PROD_W + erm_pkg::SCALE_BITS;
  localparam int unsigned SUM_W  = RATE_WIDTH + 4;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);
  localparam logic [RATE_WIDTH-1:0] RATE_MAX = '1;
  localparam logic [5:0] TEN_SH_LAST = 6'd32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_SCALE1,
    S_SCALE2,
    S_RATE_GO,
    S_RATE_WAIT,
    S_BLEND,
    S_TEN_SEED,
    S_TEN_STEP,
    S_TEN_SHIFT,
    S_TEN_REM,
    S_TEN_FIX,
    S_FIN
  } state_e;

  state_e                      state_q;
  logic [erm_pkg::FREQ_W-1:0]  freq_q;
  logic [erm_pkg::COUNT_W-1:0] count_q;
  logic [TIME_WIDTH-1:0]       start_q;
  logic                        open_q;
  logic [RATE_WIDTH-1:0]       avg_q;
  logic                        upd_q;
  logic                        out_valid_q;
  erm_pkg::out_word_t          out_word_q;

  // payload registers
  logic                        kind_q;
  logic [TIME_WIDTH-1:0]       ts_q;
  logic [TIME_WIDTH-1:0]       elapsed_q;
  logic [PROD_W-1:0]           prod_q;
  logic [DVD_W-1:0]            acc_q;
  logic [RATE_WIDTH-1:0]       rate_q;
  logic [SUM_W-1:0]            sum_q;
  logic [SUM_W-1:0]            ten_q;
  logic [5:0]                  sh_q;
  logic [4:0]                  rem10_q;

  logic [TIME_WIDTH-1:0]       elapsed_d;
  logic [erm_pkg::COUNT_W-1:0] count_inc;
  logic                        close_win;
  logic [RATE_WIDTH-1:0]       rate_d;
  logic [RATE_WIDTH+31:0]      avg_ext;
  logic [erm_pkg::OUT_W-1:0]   avg_sat;

  logic                        div_start;
  logic [DVD_W-1:0]            div_dvd;
  logic [TIME_WIDTH-1:0]       div_dvs;
  logic [CNT_W-1:0]            div_steps;
  logic [RATE_WIDTH-1:0]       div_quo;
  erm_pkg::div_stat_t          div_stat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // window bookkeeping
  always_comb begin
    elapsed_d = ts_q - start_q;
    count_inc = (count_q == erm_pkg::COUNT_MAX) ? count_q : count_q + erm_pkg::COUNT_W'(1);
    close_win = (elapsed_d >= TIME_WIDTH'(freq_q >> 2));
  end

  // measured rate; a zero elapsed time overflows the divider and saturates too
  assign rate_d = div_stat.ovf ? RATE_MAX : div_quo;

  // output saturation to 32 bits
  always_comb begin
    avg_ext = {32'b0, avg_q};
    avg_sat = (|avg_ext[RATE_WIDTH+31:32]) ? erm_pkg::OUT_MAX : avg_ext[31:0];
  end

  // divider operands: count * freq * 1000 over the elapsed ticks
  assign div_start = (state_q == S_RATE_GO);
  assign div_dvd   = acc_q;
  assign div_dvs   = elapsed_q;
  assign div_steps = CNT_W'(DVD_W);

  erm_div #(
    .DVD_WIDTH (DVD_W),
    .DVS_WIDTH (TIME_WIDTH),
    .QUO_WIDTH (RATE_WIDTH),
    .CNT_W     (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .steps_i    (div_steps),
    .quot_o     (div_quo),
    .stat_o     (div_stat)
  );

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      freq_q      <= erm_pkg::TIMER_FREQ_RST;
      count_q     <= '0;
      start_q     <= '0;
      open_q      <= 1'b0;
      avg_q       <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        freq_q <= cfg_data_i;
      end
      // result taken; a finishing word reloads it below
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          upd_q   <= 1'b0;
          state_q <= S_FIN;
          if (kind_q == erm_pkg::KIND_CLEAR) begin
            count_q <= '0;
            start_q <= '0;
            open_q  <= 1'b0;
            avg_q   <= '0;
          end else if (freq_q != '0) begin
            if (!open_q) begin
              open_q  <= 1'b1;
              start_q <= ts_q;
              count_q <= erm_pkg::COUNT_W'(1);
            end else begin
              count_q <= count_inc;
              if (close_win) begin
                start_q <= ts_q;
                upd_q   <= 1'b1;
                state_q <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          count_q <= '0;
          state_q <= S_SCALE1;
        end
        S_SCALE1: state_q <= S_SCALE2;
        S_SCALE2: state_q <= S_RATE_GO;
        S_RATE_GO: state_q <= S_RATE_WAIT;
        S_RATE_WAIT: begin
          if (div_stat.done) begin
            if (avg_q == '0) begin
              avg_q   <= rate_d;
              state_q <= S_FIN;
            end else begin
              state_q <= S_BLEND;
            end
          end
        end
        S_BLEND: state_q <= S_TEN_SEED;
        S_TEN_SEED: state_q <= S_TEN_STEP;
        S_TEN_STEP: begin
          if (sh_q == TEN_SH_LAST) begin
            state_q <= S_TEN_SHIFT;
          end
        end
        S_TEN_SHIFT: state_q <= S_TEN_REM;
        S_TEN_REM: state_q <= S_TEN_FIX;
        // estimate is at most one low
        S_TEN_FIX: begin
          avg_q   <= RATE_WIDTH'(ten_q + SUM_W'(rem10_q >= 5'(erm_pkg::BLEND_DIV)));
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q              <= 1'b1;
            out_word_q.rate_milli_hz <= avg_sat;
            out_word_q.updated       <= upd_q;
            state_q                  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      kind_q <= in_word_i.kind;
      ts_q   <= in_word_i.timestamp[TIME_WIDTH-1:0];
    end
    if (state_q == S_EVAL) begin
      elapsed_q <= elapsed_d;
    end
    // count * freq, 32x32
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(count_q) * PROD_W'(freq_q);
    end
    // x1000 = x1024 - x16 - x8
    if (state_q == S_SCALE1) begin
      acc_q <= (DVD_W'(prod_q) << 10) - (DVD_W'(prod_q) << 4);
    end
    if (state_q == S_SCALE2) begin
      acc_q <= acc_q - (DVD_W'(prod_q) << 3);
    end
    if (state_q == S_RATE_WAIT && div_stat.done) begin
      rate_q <= rate_d;
    end
    // 4*rate + 6*avg
    if (state_q == S_BLEND) begin
      sum_q <= (SUM_W'(rate_q) << 2) + (SUM_W'(avg_q) << 2) + (SUM_W'(avg_q) << 1);
    end
    // divide by ten: x * 0.8 by shift-add refinement, then /8
    if (state_q == S_TEN_SEED) begin
      ten_q <= (sum_q >> 1) + (sum_q >> 2);
      sh_q  <= 6'd4;
    end
    if (state_q == S_TEN_STEP) begin
      ten_q <= ten_q + (ten_q >> sh_q);
      sh_q  <= sh_q << 1;
    end
    if (state_q == S_TEN_SHIFT) begin
      ten_q <= ten_q >> 3;
    end
    // remainder of the estimate, below 20
    if (state_q == S_TEN_REM) begin
      rem10_q <= 5'(sum_q - ((ten_q << 3) + (ten_q << 1)));
    end
  end

endmodule

// File: rtl/core/erm_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, dividend fed MSB first.
// Quotient bits that fall off the top of quot_o raise the overflow flag.
module erm_div #(
  parameter int unsigned DVD_WIDTH = 74,
  parameter int unsigned DVS_WIDTH = 64,
  parameter int unsigned QUO_WIDTH = 32,
  parameter int unsigned CNT_W     = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DVD_WIDTH-1:0]  dividend_i,
  input  logic [DVS_WIDTH-1:0]  divisor_i,
  input  logic [CNT_W-1:0]      steps_i,
  output logic [QUO_WIDTH-1:0]  quot_o,
  output erm_pkg::div_stat_t    stat_o
);

  logic [DVD_WIDTH-1:0] dvd_q;
  logic [DVS_WIDTH-1:0] dvs_q;
  logic [DVS_WIDTH-1:0] rem_q, rem_d;
  logic [QUO_WIDTH-1:0] quo_q;
  logic                 ovf_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;

  logic [DVS_WIDTH:0] shifted, diff;
  logic               fits;

  // one shift-compare-subtract step
  always_comb begin
    shifted = {rem_q, dvd_q[DVD_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
    rem_d   = fits ? diff[DVS_WIDTH-1:0] : shifted[DVS_WIDTH-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= steps_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_WIDTH-2:0], fits};
      ovf_q <= ovf_q | quo_q[QUO_WIDTH-1];
    end
  end

  assign quot_o      = quo_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

// File: rtl/core/erm_checker.sv
`timescale 1ns / 1ps

module erm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input erm_pkg::out_word_t         out_word_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // an accepted word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting a word");

  // a new result only comes out of a word in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without a word in work");

  // the block goes idle only by handing its result to the output register
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("went idle without a result word");

endmodule

bind event_rate_meter_ema erm_checker u_erm_checker (.*);
